// File: hdl/bvp_pkg.sv
// Shared types, widths and the discharge-curve tables of the battery percent converter.
package bvp_pkg;

	// Field widths of the input and result beats.
	localparam int MV_W      = 16;
	localparam int PCT_W     = 7;

	// The curve table and its index width.
	localparam int TABLE_POINTS = 21;
	localparam int TBL_IDX_W    = 5;

	// Widest segment of the curve is 310 mV, so offsets and widths fit in ten bits.
	localparam int DEN_W = 10;
	// Quotient bits of the rounding divide; a segment never spans more than 100 percent.
	localparam int QUO_W = 7;
	localparam int CNT_W = 3;
	// Width of the shared subtractor: holds the dividend and the widest shifted divisor.
	localparam int ALU_W = 17;

	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

	// Breakpoint voltages in mV, falling strictly from full to empty.
	localparam logic [MV_W-1:0] MV_TABLE [TABLE_POINTS] = '{
		16'd4200, 16'd4150, 16'd4110, 16'd4080, 16'd4020, 16'd3980, 16'd3950,
		16'd3910, 16'd3870, 16'd3850, 16'd3840, 16'd3820, 16'd3800, 16'd3790,
		16'd3770, 16'd3750, 16'd3730, 16'd3710, 16'd3690, 16'd3610, 16'd3300
	};

	// Charge in percent at each breakpoint.
	localparam logic [PCT_W-1:0] PCT_TABLE [TABLE_POINTS] = '{
		7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
		7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
		7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
	};

	// Operands of the shared subtractor.
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	// Difference and borrow; no borrow means a >= b.
	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             borrow;
	} alu_rsp_t;

	// Finished result offered by the sequencer to the output register.
	typedef struct packed {
		logic             valid;
		logic [PCT_W-1:0] percent;
	} seq_res_t;

endpackage

// File: hdl/bvp_in_if.sv
// Input channel carrying one cell voltage per beat.
interface bvp_in_if;
	logic                      valid;
	logic                      ready;
	logic [bvp_pkg::MV_W-1:0]  cell_millivolts;

	modport source (output valid, output cell_millivolts, input ready);
	modport sink   (input valid, input cell_millivolts, output ready);
endinterface

// File: hdl/bvp_out_if.sv
// Output channel carrying one charge percentage per beat.
interface bvp_out_if;
	logic                      valid;
	logic                      ready;
	logic [bvp_pkg::PCT_W-1:0] charge_percent;

	modport source (output valid, output charge_percent, input ready);
	modport sink   (input valid, input charge_percent, output ready);
endinterface

// File: hdl/battery_voltage_to_percent.sv
// Top level of the battery voltage to charge percent converter.
//
// Converts one cell voltage in mV to a charge percentage from a fixed
// 21-point lithium-polymer discharge curve, interpolating linearly between
// breakpoints and rounding half up. Voltages at or above 4200 mV give 100,
// at or below the last curve point give 0. One beat is worked at a time
// through a single shared subtractor: a voltage outside the curve finishes
// at a range check, one inside it goes through two range checks, a binary
// search of at most five compares, offset and width, one multiply and
// seven divide steps. The result sits in an output
// register, so the next beat can be accepted while it waits to be taken.
// CURVE_POINTS sets how many table points are used, from 2 to 21; larger
// values use the whole table.
module battery_voltage_to_percent #(
	parameter int CURVE_POINTS = 21
) (
	input  logic     clk,
	input  logic     arst_n,
	bvp_in_if.sink   voltage,
	bvp_out_if.source percent
);

	bvp_pkg::alu_req_t          alu_req;
	bvp_pkg::alu_rsp_t          alu_rsp;
	bvp_pkg::seq_res_t          res;
	logic                       res_take;
	logic                       out_valid_q;
	logic [bvp_pkg::PCT_W-1:0]  out_pct_q;

	bvp_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	bvp_seq #(
		.CURVE_POINTS (CURVE_POINTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (voltage.valid),
		.in_ready (voltage.ready),
		.in_mv    (voltage.cell_millivolts),
		.alu_req  (alu_req),
		.alu_rsp  (alu_rsp),
		.res      (res),
		.res_take (res_take)
	);

	// The output register takes a result when it is empty or being drained.
	assign res_take = res.valid && (!out_valid_q || percent.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (percent.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_pct_q <= res.percent;
	end

	assign percent.valid          = out_valid_q;
	assign percent.charge_percent = out_pct_q;

endmodule

// File: hdl/bvp_alu.sv
// Shared subtract and compare unit used by the range check, search, offset, width and divide steps of the sequencer.
module bvp_alu (
	input  bvp_pkg::alu_req_t req,
	output bvp_pkg::alu_rsp_t rsp
);

	logic [bvp_pkg::ALU_W:0] full;

	// One wide subtract; the top bit is the borrow.
	assign full       = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff   = full[bvp_pkg::ALU_W-1:0];
	assign rsp.borrow = full[bvp_pkg::ALU_W];

endmodule

// File: hdl/bvp_seq.sv
// Sequencer: range checks, binary search of the curve, and a restoring divide.
module bvp_seq #(
	parameter int CURVE_POINTS = 21
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bvp_pkg::MV_W-1:0]  in_mv,
	output bvp_pkg::alu_req_t         alu_req,
	input  bvp_pkg::alu_rsp_t         alu_rsp,
	output bvp_pkg::seq_res_t         res,
	input  logic                      res_take
);

	// Points in use, held to at least 2 and at most what the table provides.
	localparam int N_USED = (CURVE_POINTS > bvp_pkg::TABLE_POINTS) ? bvp_pkg::TABLE_POINTS :
		((CURVE_POINTS < 2) ? 2 : CURVE_POINTS);
	localparam int IDX_W  = (N_USED > 1) ? $clog2(N_USED) : 1;
	localparam int TW     = bvp_pkg::TBL_IDX_W;
	localparam int AW     = bvp_pkg::ALU_W;

	localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(N_USED - 1);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TOP  = 4'd1;
	localparam logic [3:0] S_BOT  = 4'd2;
	localparam logic [3:0] S_SRCH = 4'd3;
	localparam logic [3:0] S_OFF  = 4'd4;
	localparam logic [3:0] S_DEN  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]                     state_q;
	logic [bvp_pkg::MV_W-1:0]       v_q;
	logic [IDX_W-1:0]               lo_q;
	logic [IDX_W-1:0]               hi_q;
	logic [bvp_pkg::DEN_W-1:0]      off_q;
	logic [bvp_pkg::DEN_W-1:0]      den_q;
	logic [AW-1:0]                  rem_q;
	logic [bvp_pkg::QUO_W-1:0]      quo_q;
	logic [bvp_pkg::CNT_W-1:0]      k_q;
	logic [bvp_pkg::PCT_W-1:0]      pct_q;

	logic [IDX_W:0]                 mid_sum;
	logic [IDX_W-1:0]               mid;
	logic [IDX_W-1:0]               lo_prev;
	logic [TW-1:0]                  t_mid;
	logic [TW-1:0]                  t_lo;
	logic [TW-1:0]                  t_prev;
	logic [bvp_pkg::PCT_W-1:0]      pct_span;
	logic [AW-1:0]                  prod;
	logic [AW-1:0]                  dividend;
	logic                           ge;
	logic [bvp_pkg::QUO_W-1:0]      quo_next;

	// Search midpoint and table addresses.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign lo_prev = lo_q - IDX_W'(1);
	assign t_mid   = TW'(mid);
	assign t_lo    = TW'(lo_q);
	assign t_prev  = TW'(lo_prev);

	// Percent span of the segment and the rounded-up dividend.
	assign pct_span = bvp_pkg::PCT_TABLE[t_prev] - bvp_pkg::PCT_TABLE[t_lo];
	assign prod     = AW'(off_q) * AW'(pct_span);
	assign dividend = prod + AW'(den_q >> 1);

	assign ge       = !alu_rsp.borrow;
	assign quo_next = {quo_q[bvp_pkg::QUO_W-2:0], ge};

	assign in_ready    = (state_q == S_IDLE);
	assign res.valid   = (state_q == S_DONE);
	assign res.percent = pct_q;

	// Operand selection for the shared subtractor.
	always_comb begin
		alu_req.a = '0;
		alu_req.b = '0;
		case (state_q)
			S_TOP: begin
				alu_req.a = AW'(v_q);
				alu_req.b = AW'(bvp_pkg::MV_TABLE[0]);
			end
			S_BOT: begin
				alu_req.a = AW'(bvp_pkg::MV_TABLE[TW'(IDX_LAST)]);
				alu_req.b = AW'(v_q);
			end
			S_SRCH: begin
				alu_req.a = AW'(v_q);
				alu_req.b = AW'(bvp_pkg::MV_TABLE[t_mid]);
			end
			S_OFF: begin
				alu_req.a = AW'(v_q);
				alu_req.b = AW'(bvp_pkg::MV_TABLE[t_lo]);
			end
			S_DEN: begin
				alu_req.a = AW'(bvp_pkg::MV_TABLE[t_prev]);
				alu_req.b = AW'(bvp_pkg::MV_TABLE[t_lo]);
			end
			S_DIV: begin
				alu_req.a = rem_q;
				alu_req.b = AW'(den_q) << k_q;
			end
			default: begin
				alu_req.a = '0;
				alu_req.b = '0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_TOP;
				S_TOP:  state_q <= ge ? S_DONE : S_BOT;
				S_BOT:  state_q <= ge ? S_DONE : S_SRCH;
				S_SRCH: if (lo_q == hi_q) state_q <= S_OFF;
				S_OFF:  state_q <= S_DEN;
				S_DEN:  state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV:  if (k_q == '0) state_q <= S_DONE;
				S_DONE: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) v_q <= in_mv;
			end
			S_TOP: begin
				pct_q <= bvp_pkg::PCT_FULL;
			end
			S_BOT: begin
				pct_q <= bvp_pkg::PCT_EMPTY;
				lo_q  <= IDX_FIRST;
				hi_q  <= IDX_LAST;
			end
			S_SRCH: begin
				// Narrow to the first breakpoint at or below the voltage.
				if (lo_q != hi_q) begin
					if (ge) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid + IDX_W'(1);
					end
				end
			end
			S_OFF: begin
				off_q <= alu_rsp.diff[bvp_pkg::DEN_W-1:0];
			end
			S_DEN: begin
				den_q <= alu_rsp.diff[bvp_pkg::DEN_W-1:0];
			end
			S_MUL: begin
				rem_q <= dividend;
				quo_q <= '0;
				k_q   <= bvp_pkg::CNT_W'(bvp_pkg::QUO_W - 1);
			end
			S_DIV: begin
				// One restoring quotient bit per cycle, most significant first.
				if (ge) rem_q <= alu_rsp.diff;
				quo_q <= quo_next;
				k_q   <= k_q - bvp_pkg::CNT_W'(1);
				if (k_q == '0) pct_q <= bvp_pkg::PCT_TABLE[t_lo] + quo_next;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: test/tb_battery_voltage_to_percent.sv
// Self-checking testbench for the battery voltage to charge percent converter.
`timescale 1ns / 1ps

module tb_battery_voltage_to_percent;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_BEATS  = 1028;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PRINT_LIMIT   = 20;
	localparam int NOT_TYPED     = -1;

	// Field widths and end values of the block.
	localparam int MV_W  = bvp_pkg::MV_W;
	localparam int PCT_W = bvp_pkg::PCT_W;
	localparam logic [PCT_W-1:0] PCT_FULL  = bvp_pkg::PCT_FULL;
	localparam logic [PCT_W-1:0] PCT_EMPTY = bvp_pkg::PCT_EMPTY;

	// Curve length as the block is built, clamped to the table the same way.
	localparam int CURVE_POINTS = 21;
	localparam int KNEES     = 21;
	localparam int KNEES_USED = (CURVE_POINTS > KNEES) ? KNEES :
		((CURVE_POINTS < 2) ? 2 : CURVE_POINTS);

	// Discharge curve knees, falling from full to empty.
	localparam int unsigned KNEE_MV [KNEES] = '{
		4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
		3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3300
	};
	localparam int unsigned KNEE_PCT [KNEES] = '{
		100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
		45, 40, 35, 30, 25, 20, 15, 10, 5, 0
	};

	// One directed beat: the voltage and, where obvious, the percent it must give.
	typedef struct {
		logic [MV_W-1:0] mv;
		int              typed_pct;
	} voltage_row_t;

	localparam int DIRECTED_ROWS = 22;
	voltage_row_t directed_voltages [DIRECTED_ROWS] = '{
		'{16'd0,     PCT_EMPTY},
		'{16'd65535, PCT_FULL},
		'{16'd4200,  PCT_FULL},
		'{16'd4201,  PCT_FULL},
		'{16'd3300,  PCT_EMPTY},
		'{16'd3299,  PCT_EMPTY},
		'{16'h8000,  PCT_FULL},
		'{16'h5555,  PCT_FULL},
		'{16'h0AAA,  PCT_EMPTY},
		'{16'h00FF,  PCT_EMPTY},
		'{16'd4150,  95},
		'{16'd3850,  55},
		'{16'd3840,  50},
		'{16'd3690,  10},
		'{16'd3610,  5},
		'{16'd4199,  NOT_TYPED},
		'{16'd3301,  NOT_TYPED},
		'{16'd4175,  NOT_TYPED},
		'{16'd3455,  NOT_TYPED},
		'{16'd3845,  NOT_TYPED},
		'{16'd3795,  NOT_TYPED},
		'{16'd3611,  NOT_TYPED}
	};

	logic clk;
	logic arst_n;

	bvp_in_if  voltage_ch ();
	bvp_out_if percent_ch ();

	battery_voltage_to_percent i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.voltage (voltage_ch),
		.percent (percent_ch)
	);

	logic [PCT_W-1:0] pending_percent [$];
	int               mismatch_count;
	int               beats_checked;
	int               beats_on_curve;
	int               cycle_count;
	bit               steady_flow;

	// Expected charge for one voltage: saturate at both ends, else interpolate.
	function automatic logic [PCT_W-1:0] charge_from_mv(input logic [MV_W-1:0] mv);
		int unsigned v;
		int unsigned lo_mv;
		int unsigned hi_mv;
		int unsigned lo_pct;
		int unsigned hi_pct;
		int unsigned span;
		int unsigned scaled;
		int          k;
		v = mv;
		if (v >= KNEE_MV[0]) begin
			return PCT_FULL;
		end
		if (v <= KNEE_MV[KNEES_USED-1]) begin
			return PCT_EMPTY;
		end
		for (k = 1; k < KNEES_USED; k++) begin
			if (v >= KNEE_MV[k]) begin
				lo_mv  = KNEE_MV[k];
				hi_mv  = KNEE_MV[k-1];
				lo_pct = KNEE_PCT[k];
				hi_pct = KNEE_PCT[k-1];
				span   = hi_mv - lo_mv;
				scaled = (v - lo_mv) * (hi_pct - lo_pct);
				if (span == 0) begin
					return lo_pct[PCT_W-1:0];
				end
				return PCT_W'(lo_pct + (scaled + span / 2) / span);
			end
		end
		return PCT_EMPTY;
	endfunction

	// Random voltage, weighted toward the curve and the neighborhood of its knees.
	function automatic logic [MV_W-1:0] pick_voltage();
		int unsigned knee;
		case ($urandom_range(0, 9))
			0, 1: begin
				return MV_W'($urandom);
			end
			2, 3: begin
				knee = $urandom_range(0, KNEES - 1);
				return MV_W'(KNEE_MV[knee] + $urandom_range(0, 6) - 3);
			end
			default: begin
				return MV_W'($urandom_range(3300, 4200));
			end
		endcase
	endfunction

	// Wait before a beat on either side; long stretches run with no gaps at all.
	function automatic int draw_wait();
		if (steady_flow) begin
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("[%0t] ERROR: %s", $realtime, what);
		end
	endtask

	// Offer one voltage beat; called just after a falling edge, returns just after one.
	task automatic send_voltage(input logic [MV_W-1:0] mv, input int typed_pct);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			voltage_ch.valid           = 1'b0;
			voltage_ch.cell_millivolts = MV_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		voltage_ch.valid           = 1'b1;
		voltage_ch.cell_millivolts = mv;
		do @(posedge clk); while (!voltage_ch.ready);
		if (typed_pct == NOT_TYPED) begin
			pending_percent.push_back(charge_from_mv(mv));
		end else begin
			pending_percent.push_back(PCT_W'(typed_pct));
		end
		if (mv > KNEE_MV[KNEES_USED-1] && mv < KNEE_MV[0]) begin
			beats_on_curve++;
		end
		@(negedge clk);
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("battery_voltage_to_percent: mismatch");
			$finish;
		end
	end

	// Result side: stall at random, then take one beat and compare it.
	initial begin
		logic [PCT_W-1:0] want;
		int               stall;
		percent_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				percent_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			percent_ch.ready = 1'b1;
			do @(posedge clk); while (!percent_ch.valid);
			beats_checked++;
			if (pending_percent.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat, charge_percent=%0d",
					percent_ch.charge_percent));
			end else begin
				want = pending_percent.pop_front();
				if (percent_ch.charge_percent !== want) begin
					report_mismatch($sformatf("charge_percent=%0d, expected %0d",
						percent_ch.charge_percent, want));
				end
			end
			@(negedge clk);
		end
	end

	// Stimulus: reset, directed rows, then random voltages, then drain.
	initial begin
		int row;
		int n;
		mismatch_count             = 0;
		beats_checked              = 0;
		beats_on_curve             = 0;
		cycle_count                = 0;
		steady_flow                = 1'b0;
		voltage_ch.valid           = 1'b0;
		voltage_ch.cell_millivolts = '0;
		arst_n                     = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			send_voltage(directed_voltages[row].mv, directed_voltages[row].typed_pct);
		end

		for (n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 39) == 0) begin
				steady_flow = !steady_flow;
			end
			send_voltage(pick_voltage(), NOT_TYPED);
		end
		voltage_ch.valid = 1'b0;

		// Let every expected beat come out, then watch for stray ones.
		while (pending_percent.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result beats; %0d voltages fell inside the curve.",
			beats_checked, beats_on_curve);
		if (mismatch_count == 0) begin
			$display("battery_voltage_to_percent: match");
		end else begin
			$display("battery_voltage_to_percent: mismatch");
		end
		$finish;
	end

endmodule

// File: battery_voltage_to_percent.f
hdl/bvp_pkg.sv
hdl/bvp_in_if.sv
hdl/bvp_out_if.sv
hdl/bvp_alu.sv
hdl/bvp_seq.sv
hdl/battery_voltage_to_percent.sv
test/tb_battery_voltage_to_percent.sv
